>>> design/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; imported by spq_cell, sorted_priority_queue and tb_top.
`default_nettype none
package spq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int TAG_W        = 8;
    localparam int PRI_W        = 8;
    localparam int OCC_W        = 5;
    localparam int STATUS_W     = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic [TAG_W-1:0] info;
        logic [PRI_W-1:0] pri;
    } entry_t;

    // broadcast to every cell of the row
    typedef struct packed {
        logic   shift_in;   // sorted insert of item
        logic   shift_out;  // remove head, row moves toward slot 0
        entry_t item;
    } cell_ctrl_t;

endpackage
`default_nettype wire

>>> design/spq_cell.sv
// One slot of the sorted row: holds an entry and trades it with neighbors.
// Depends on spq_pkg.
`default_nettype none
module spq_cell (
    input  wire logic               aclk,
    input  wire spq_pkg::cell_ctrl_t ctrl,
    input  wire logic               self_valid,
    input  wire spq_pkg::entry_t    left_entry,
    input  wire logic               left_gt,
    input  wire spq_pkg::entry_t    right_entry,
    output spq_pkg::entry_t         entry,
    output logic                    gt
);
    import spq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // slot is a place for the new item, or behind it
    assign gt    = !self_valid || (entry_reg.pri > ctrl.item.pri);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.shift_in && gt) begin
            entry_next = left_gt ? left_entry : ctrl.item;
        end else if (ctrl.shift_out) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule
`default_nettype wire

>>> design/sorted_priority_queue.sv
// Top level of the sorted priority queue: cell row, fill count, result register.
// Depends on spq_pkg and spq_cell.
`default_nettype none
// Channel  Dir  tdata (low bit up)                          tuser (low bit up)
// s_       in   item_info[7:0] item_priority[15:8]          command[0]
// m_       out  out_info[7:0] out_priority[15:8]            status[1:0] out_valid[2]
//               occupancy[20:16], zero pad [23:21]
//
// One word per cycle: each accepted word updates the whole cell row in the
// same cycle (sorted insert or head removal), and its result appears in the
// output register in the next cycle.
// Reset (aresetn low, synchronous) empties the queue and the output register.
// A new word is taken while the output register is empty or being drained;
// with m_tready low and a result waiting, s_tready drops and everything holds.
module sorted_priority_queue #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // item_info[7:0], item_priority[15:8]
    input  wire logic [0:0]  s_tuser,   // command[0]: 0 enqueue, 1 dequeue
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // out_info[7:0], out_priority[15:8],
                                        // occupancy[20:16], zero [23:21]
    output logic [2:0]       m_tuser    // status[1:0], out_valid[2]
);
    import spq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic             accept;
    logic             cmd_deq;
    logic             full;
    logic             empty;
    cell_ctrl_t       ctrl;

    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;

    entry_t           cell_entry [CAPACITY];
    logic             cell_gt    [CAPACITY];

    // result register
    logic             m_valid_reg;
    logic             m_valid_next;
    status_t          status_reg;
    status_t          status_next;
    logic             outv_reg;
    logic             outv_next;
    entry_t           out_entry_reg;
    entry_t           out_entry_next;
    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign cmd_deq  = s_tuser[0];
    assign full     = (count_reg == CW'(CAPACITY));
    assign empty    = (count_reg == '0);

    // broadcast the operation to the row only when it changes the queue
    always_comb begin
        ctrl.shift_in  = accept && !cmd_deq && !full;
        ctrl.shift_out = accept && cmd_deq && !empty;
        ctrl.item.info = s_tdata[7:0];
        ctrl.item.pri  = s_tdata[15:8];
    end

    // the cell row; slot 0 is the head
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        entry_t left_e;
        logic   left_g;
        entry_t right_e;
        logic   valid_i;

        assign valid_i = (CW'(i) < count_reg);

        if (i == 0) begin : g_first
            assign left_e = ctrl.item;
            assign left_g = 1'b0;
        end else begin : g_mid
            assign left_e = cell_entry[i-1];
            assign left_g = cell_gt[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_e = cell_entry[i];   // falls out of the count anyway
        end else begin : g_inner
            assign right_e = cell_entry[i+1];
        end

        spq_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .self_valid  (valid_i),
            .left_entry  (left_e),
            .left_gt     (left_g),
            .right_entry (right_e),
            .entry       (cell_entry[i]),
            .gt          (cell_gt[i])
        );
    end

    // fill count and result formation
    always_comb begin
        count_next     = count_reg;
        m_valid_next   = m_valid_reg;
        status_next    = status_reg;
        outv_next      = outv_reg;
        out_entry_next = out_entry_reg;
        occ_next       = occ_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        if (ctrl.shift_in) begin
            count_next = count_reg + CW'(1);
        end else if (ctrl.shift_out) begin
            count_next = count_reg - CW'(1);
        end

        if (accept) begin
            m_valid_next   = 1'b1;
            outv_next      = 1'b0;
            out_entry_next = '0;
            status_next    = ST_DONE;
            if (!cmd_deq) begin
                if (full) begin
                    status_next = ST_FULL;
                end
            end else if (empty) begin
                status_next = ST_EMPTY;
            end else begin
                outv_next      = 1'b1;
                out_entry_next = cell_entry[0];
            end
            occ_next = OCC_W'(count_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        status_reg    <= status_next;
        outv_reg      <= outv_next;
        out_entry_reg <= out_entry_next;
        occ_reg       <= occ_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, occ_reg, out_entry_reg.pri, out_entry_reg.info};
    assign m_tuser  = {outv_reg, status_reg};

    // count never runs past the row
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("fill count beyond capacity");

    // a returned entry only comes with a done status
    a_outv_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && outv_reg |-> status_reg == ST_DONE)
        else $error("returned entry with error status");

    // a dropped enqueue leaves the count alone
    a_drop_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !cmd_deq && full |=> count_reg == $past(count_reg))
        else $error("dropped enqueue changed the count");

    // a successful dequeue lowers the count by one
    a_deq_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.shift_out |=> count_reg == $past(count_reg) - CW'(1))
        else $error("dequeue count mismatch");

endmodule
`default_nettype wire

>>> bench/tb_top.sv
// Self-checking bench for sorted_priority_queue: a short table of directed words, then
// random bursts; results are checked against table entries or a behavioral queue model.
// Depends on spq_pkg and the design sources of sorted_priority_queue.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int  CAPACITY       = CAPACITY_DEF;
    localparam int  RANDOM_ITEMS   = 800;
    localparam int  WATCHDOG_LIMIT = 2000;
    localparam int  DRAIN_CYCLES   = 4;
    localparam bit  CMD_ENQ        = 1'b0;
    localparam bit  CMD_DEQ        = 1'b1;

    // one result word, field by field
    typedef struct packed {
        status_t          status;
        logic             valid;
        logic [TAG_W-1:0] info;
        logic [PRI_W-1:0] pri;
        logic [OCC_W-1:0] occ;
    } result_t;

    // one row of the directed table; want is used only when typed is set
    typedef struct {
        logic             cmd;
        logic [TAG_W-1:0] info;
        logic [PRI_W-1:0] pri;
        bit               typed;
        result_t          want;
    } stim_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;     // item_info[7:0], item_priority[15:8]
    logic [0:0]  s_tuser  = '0;     // command[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;           // out_info[7:0], out_priority[15:8], occupancy[20:16]
    logic [2:0]  m_tuser;           // status[1:0], out_valid[2]

    // model copy of the queue contents, slot 0 is the head
    logic [TAG_W-1:0] held_info [CAPACITY];
    logic [PRI_W-1:0] held_pri  [CAPACITY];
    int               held_count = 0;

    result_t   pending_results[$];
    stim_row_t directed_rows[$];
    int        errors  = 0;
    bit        no_idle = 1'b0;

    sorted_priority_queue #(.CAPACITY(CAPACITY)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Apply one word to the model queue and return the result it must produce.
    // Insert before the first entry with a strictly greater priority, so ties
    // keep arrival order; drop on full, flag on empty.
    function automatic void queue_model(input logic cmd, input logic [TAG_W-1:0] info,
                                        input logic [PRI_W-1:0] pri, output result_t r);
        int pos;
        r = '0;
        r.status = ST_DONE;
        if (cmd == CMD_ENQ) begin
            if (held_count >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < held_count && held_pri[pos] <= pri)
                    pos++;
                for (int k = held_count; k > pos; k--) begin
                    held_info[k] = held_info[k-1];
                    held_pri[k]  = held_pri[k-1];
                end
                held_info[pos] = info;
                held_pri[pos]  = pri;
                held_count++;
            end
        end else if (held_count == 0) begin
            r.status = ST_EMPTY;
        end else begin
            r.valid = 1'b1;
            r.info  = held_info[0];
            r.pri   = held_pri[0];
            for (int k = 1; k < held_count; k++) begin
                held_info[k-1] = held_info[k];
                held_pri[k-1]  = held_pri[k];
            end
            held_count--;
        end
        r.occ = OCC_W'(held_count);
    endfunction

    function automatic void add_row(logic cmd, logic [TAG_W-1:0] info, logic [PRI_W-1:0] pri,
                                    bit typed = 1'b0, status_t st = ST_DONE, int occ = 0);
        stim_row_t row;
        row.cmd         = cmd;
        row.info        = info;
        row.pri         = pri;
        row.typed       = typed;
        row.want        = '0;
        row.want.status = st;
        row.want.occ    = OCC_W'(occ);
        directed_rows.push_back(row);
    endfunction

    // Mostly short idles, now and then a long one.
    function automatic int idle_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Offer one word, hold it until taken, then log what it must produce.
    task automatic send_item(logic cmd, logic [TAG_W-1:0] info, logic [PRI_W-1:0] pri,
                             bit typed = 1'b0, result_t typed_want = '0);
        result_t predicted;
        int      gap;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {pri, info};
        do @(posedge aclk); while (!s_tready);
        queue_model(cmd, info, pri, predicted);
        pending_results.push_back(typed ? typed_want : predicted);
        // leave valid high for a back-to-back word, otherwise drop it for the gap
        gap = (no_idle || $urandom_range(0, 9) < 6) ? 0 : idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Result side: random backpressure, with stretches of none while no_idle is set.
    int stall_left = 0;
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            m_tready <= 1'b0;
            stall_left = idle_len() - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare every accepted result word against the oldest expectation.
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual %h/%h",
                         $time, m_tuser, m_tdata);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("status",       8'(want.status), 8'(m_tuser[1:0]));
                check_field("out_valid",    8'(want.valid),  8'(m_tuser[2]));
                check_field("out_info",     want.info,       m_tdata[7:0]);
                check_field("out_priority", want.pri,        m_tdata[15:8]);
                check_field("occupancy",    8'(want.occ),    8'(m_tdata[20:16]));
            end
        end
    end

    // Abort when neither side moves a word for too long.
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int          sent;
        int          burst;
        int          enq_pct;
        int          pri_mode;
        logic        cmd;
        logic [7:0]  info;
        logic [7:0]  pri;

        // Directed table: empty dequeue, fill to capacity with extreme tags and
        // priorities and several ties, a dropped enqueue on full, then a few dequeues and an enqueue.
        add_row(CMD_DEQ, 8'h00, 8'h00, 1'b1, ST_EMPTY, 0);
        add_row(CMD_ENQ, 8'hFF, 8'hFF, 1'b1, ST_DONE, 1);
        add_row(CMD_ENQ, 8'h00, 8'h00, 1'b1, ST_DONE, 2);
        add_row(CMD_ENQ, 8'h11, 8'h80, 1'b1, ST_DONE, 3);
        add_row(CMD_ENQ, 8'h22, 8'h80, 1'b1, ST_DONE, 4);
        add_row(CMD_ENQ, 8'h33, 8'h80, 1'b1, ST_DONE, 5);
        add_row(CMD_ENQ, 8'h44, 8'hFF, 1'b1, ST_DONE, 6);
        add_row(CMD_ENQ, 8'h55, 8'h00, 1'b1, ST_DONE, 7);
        add_row(CMD_ENQ, 8'hAA, 8'h7F, 1'b1, ST_DONE, 8);
        add_row(CMD_ENQ, 8'h5A, 8'h01, 1'b1, ST_DONE, 9);
        add_row(CMD_ENQ, 8'hA5, 8'hFE, 1'b1, ST_DONE, 10);
        add_row(CMD_ENQ, 8'h01, 8'h40, 1'b1, ST_DONE, 11);
        add_row(CMD_ENQ, 8'h80, 8'hC0, 1'b1, ST_DONE, 12);
        add_row(CMD_ENQ, 8'h7F, 8'h20, 1'b1, ST_DONE, 13);
        add_row(CMD_ENQ, 8'hF0, 8'h80, 1'b1, ST_DONE, 14);
        add_row(CMD_ENQ, 8'h3C, 8'h02, 1'b1, ST_DONE, 15);
        add_row(CMD_ENQ, 8'h0F, 8'h81, 1'b1, ST_DONE, 16);
        add_row(CMD_ENQ, 8'hEE, 8'h00, 1'b1, ST_FULL, 16);
        add_row(CMD_DEQ, 8'hFF, 8'hFF);
        add_row(CMD_DEQ, 8'h00, 8'h00);
        add_row(CMD_ENQ, 8'h77, 8'h00, 1'b1, ST_DONE, 15);
        add_row(CMD_DEQ, 8'h00, 8'h00);
        add_row(CMD_DEQ, 8'h00, 8'h00);

        // hold reset, then release it once
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].cmd, directed_rows[i].info, directed_rows[i].pri,
                      directed_rows[i].typed, directed_rows[i].want);

        // Random bursts: each burst leans toward filling, draining or churning the
        // queue so both the full and the empty boundaries are crossed many times.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(20, 60);
            case ($urandom_range(0, 2))
                0:       enq_pct = 15;
                1:       enq_pct = 50;
                default: enq_pct = 85;
            endcase
            pri_mode = $urandom_range(0, 3);
            no_idle  = ($urandom_range(0, 3) == 0);
            repeat (burst) begin
                cmd  = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
                info = 8'($urandom);
                case (pri_mode)
                    0:       pri = 8'($urandom_range(0, 3));   // dense ties
                    1:       pri = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    default: pri = 8'($urandom);
                endcase
                send_item(cmd, info, pri);
                sent++;
            end
        end

        // drop valid and wait out every expected result, then a short drain
        s_tvalid <= 1'b0;
        no_idle  = 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
